@@ hw/rtl/bbvg_pkg.sv @@
// shared widths, codes, constants and face frames for the bevel box vertex generator
package bbvg_pkg;

  localparam int MAX_SEGMENTS = 64;

  localparam int LEN_W     = 24;
  localparam int SEG_CFG_W = 7;
  localparam int FACE_W    = 3;
  localparam int IDX_W     = 8;
  localparam int POS_W     = 26;
  localparam int NRM_W     = 16;
  localparam int SURF_W    = 25;
  localparam int CFG_IDX_W = 3;
  localparam int Q_SHIFT   = 14;

  localparam logic signed [NRM_W-1:0] Q_ONE = NRM_W'(1) << Q_SHIFT;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 3'd7;

  localparam logic [LEN_W-1:0]     HALF_RST   = 24'd256;
  localparam logic [LEN_W-1:0]     INNER_RST  = 24'd192;
  localparam logic [LEN_W-1:0]     RADIUS_RST = 24'd64;
  localparam logic [SEG_CFG_W-1:0] SEG_RST    = 7'd4;

  // face codes
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd5;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [1:0] n_ax;
    logic       n_neg;
    logic [1:0] u_ax;
    logic       u_neg;
    logic [1:0] v_ax;
    logic       v_neg;
  } frame_t;

  function automatic frame_t frame_of(input logic [FACE_W-1:0] f);
    frame_t fr;
    unique case (f)
      FACE_FRONT:  fr = '{AX_Y, 1'b0, AX_X, 1'b0, AX_Z, 1'b1};
      FACE_BACK:   fr = '{AX_Y, 1'b1, AX_X, 1'b1, AX_Z, 1'b1};
      FACE_TOP:    fr = '{AX_Z, 1'b0, AX_X, 1'b0, AX_Y, 1'b0};
      FACE_BOTTOM: fr = '{AX_Z, 1'b1, AX_X, 1'b0, AX_Y, 1'b1};
      FACE_RIGHT:  fr = '{AX_X, 1'b0, AX_Y, 1'b1, AX_Z, 1'b1};
      FACE_LEFT:   fr = '{AX_X, 1'b1, AX_Y, 1'b0, AX_Z, 1'b1};
      default:     fr = '{AX_Y, 1'b0, AX_X, 1'b0, AX_Z, 1'b1};
    endcase
    return fr;
  endfunction

endpackage

@@ hw/rtl/bevel_box_vertex_generator_top.sv @@
// rounded box vertex generator: grid point on a face in, vertex position/normal/uv out
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_stall     face, u_index, v_index
//  vertex    out        vertex_valid / vertex_stall pos_*, norm_*, surf_u, surf_v, index_ok
//  cfg       in         cfg_we (no wait)            cfg_index, cfg_data
//
// one item per cycle unless a stalled vertex holds the pipeline; the stages are the grid step divider
// (24 stages), the bevel length square root (25 stages) and the normalizing dividers
// (25 stages) plus ten stages of setup and assembly.
// reset clears all valid bits and loads the register defaults; no clearing pass.
// a stalled vertex freezes the whole pipeline; item_stall follows vertex_stall.
module bevel_box_vertex_generator_top #(
  parameter int MAX_SEGMENTS = bbvg_pkg::MAX_SEGMENTS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [bbvg_pkg::FACE_W-1:0]            face,
  input  logic [bbvg_pkg::IDX_W-1:0]             u_index,
  input  logic [bbvg_pkg::IDX_W-1:0]             v_index,
  output logic                                   vertex_valid,
  input  logic                                   vertex_stall,
  output logic signed [bbvg_pkg::POS_W-1:0]      pos_x,
  output logic signed [bbvg_pkg::POS_W-1:0]      pos_y,
  output logic signed [bbvg_pkg::POS_W-1:0]      pos_z,
  output logic signed [bbvg_pkg::NRM_W-1:0]      norm_x,
  output logic signed [bbvg_pkg::NRM_W-1:0]      norm_y,
  output logic signed [bbvg_pkg::NRM_W-1:0]      norm_z,
  output logic [bbvg_pkg::SURF_W-1:0]            surf_u,
  output logic [bbvg_pkg::SURF_W-1:0]            surf_v,
  output logic                                   index_ok,
  input  logic                                   cfg_we,
  input  logic [bbvg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bbvg_pkg::LEN_W-1:0]             cfg_data
);

  localparam int LW      = bbvg_pkg::LEN_W;
  localparam int IW      = bbvg_pkg::IDX_W;
  localparam int FW_     = bbvg_pkg::FACE_W;
  localparam int PSW     = bbvg_pkg::POS_W;
  localparam int NW      = bbvg_pkg::NRM_W;
  localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_W   = SEG_W + 2;
  localparam int GNUM_W  = IW + LW;
  localparam int SQ_W    = 2 * LW + 2;
  localparam int LEN2_W  = SQ_W / 2;
  localparam int DN_W    = 2 * LW + 1;
  localparam int QUO2_W  = LEN2_W;
  localparam int FRW     = PSW + 2;
  localparam int PW      = FRW + 2;

  typedef struct packed {
    logic                  valid;
    logic                  bad;
    logic [FW_-1:0]        face;
    logic                  on;
    logic                  u_zero;
    logic                  v_zero;
    logic signed [PSW-1:0] base_u;
    logic signed [PSW-1:0] base_v;
  } grid_t;

  typedef struct packed {
    logic                  valid;
    logic                  bad;
    logic [FW_-1:0]        face;
    logic                  on;
    logic signed [PSW-1:0] lu;
    logic signed [PSW-1:0] lv;
  } loc_t;

  typedef struct packed {
    logic                  valid;
    logic                  bad;
    logic [FW_-1:0]        face;
    logic                  bevel;
    logic signed [PSW-1:0] lu;
    logic signed [PSW-1:0] lv;
    logic signed [PSW-1:0] cu;
    logic signed [PSW-1:0] cv;
    logic                  neg_u;
    logic                  neg_v;
    logic [LW-1:0]         mag_n;
    logic [LW-1:0]         mag_u;
    logic [LW-1:0]         mag_v;
  } geo_t;

  typedef struct packed {
    logic                  valid;
    logic                  bad;
    logic [FW_-1:0]        face;
    logic signed [PSW-1:0] lu;
    logic signed [PSW-1:0] lv;
    logic signed [FRW-1:0] pn;
    logic signed [FRW-1:0] pu;
    logic signed [FRW-1:0] pv;
    logic signed [NW-1:0]  nn;
    logic signed [NW-1:0]  nu;
    logic signed [NW-1:0]  nv;
  } fin_t;

  function automatic logic [LW-1:0] pick(input logic [1:0] ax, input logic [LW-1:0] a0,
                                         input logic [LW-1:0] a1, input logic [LW-1:0] a2);
    logic [LW-1:0] r;
    unique case (ax)
      bbvg_pkg::AX_X: r = a0;
      bbvg_pkg::AX_Y: r = a1;
      default:        r = a2;
    endcase
    return r;
  endfunction

  function automatic logic signed [PSW-1:0] sat_pos(input logic signed [PW-1:0] v);
    logic signed [PSW-1:0] r;
    if (v > PW'(bbvg_pkg::POS_MAX)) r = bbvg_pkg::POS_MAX;
    else if (v < PW'(bbvg_pkg::POS_MIN)) r = bbvg_pkg::POS_MIN;
    else r = PSW'(v);
    return r;
  endfunction

  // configuration registers
  logic [LW-1:0]                  half_x, half_y, half_z;
  logic [LW-1:0]                  inner_x, inner_y, inner_z;
  logic [LW-1:0]                  bevel_radius;
  logic [bbvg_pkg::SEG_CFG_W-1:0] bevel_segments;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_x         <= bbvg_pkg::HALF_RST;
      half_y         <= bbvg_pkg::HALF_RST;
      half_z         <= bbvg_pkg::HALF_RST;
      inner_x        <= bbvg_pkg::INNER_RST;
      inner_y        <= bbvg_pkg::INNER_RST;
      inner_z        <= bbvg_pkg::INNER_RST;
      bevel_radius   <= bbvg_pkg::RADIUS_RST;
      bevel_segments <= bbvg_pkg::SEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbvg_pkg::REG_HALF_X:   half_x         <= cfg_data;
        bbvg_pkg::REG_HALF_Y:   half_y         <= cfg_data;
        bbvg_pkg::REG_HALF_Z:   half_z         <= cfg_data;
        bbvg_pkg::REG_INNER_X:  inner_x        <= cfg_data;
        bbvg_pkg::REG_INNER_Y:  inner_y        <= cfg_data;
        bbvg_pkg::REG_INNER_Z:  inner_z        <= cfg_data;
        bbvg_pkg::REG_RADIUS:   bevel_radius   <= cfg_data;
        bbvg_pkg::REG_SEGMENTS: bevel_segments <= cfg_data[bbvg_pkg::SEG_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // derived configuration; the user keeps it static while items flow, and nothing in the block enforces this
  logic [SEG_W-1:0] seg_sat;
  logic             bevel_on;
  logic [CNT_W-1:0] grid_cnt;

  always_comb begin
    if (32'(bevel_segments) > 32'(MAX_SEGMENTS)) seg_sat = SEG_W'(MAX_SEGMENTS);
    else seg_sat = SEG_W'(bevel_segments);
  end

  assign bevel_on = (seg_sat != '0) && (bevel_radius != '0) && (half_x > inner_x) &&
                    (half_y > inner_y) && (half_z > inner_z);
  assign grid_cnt = bevel_on ? ((CNT_W'(seg_sat) + CNT_W'(1)) << 1) : CNT_W'(2);

  // whole pipeline moves unless the output holds a stalled vertex
  logic en;
  assign item_stall = vertex_valid & vertex_stall;
  assign en         = ~item_stall;

  // stage 0: input register
  logic           in_vld;
  logic [FW_-1:0] in_face;
  logic [IW-1:0]  in_u, in_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (en) begin
      in_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_face <= face;
      in_u    <= u_index;
      in_v    <= v_index;
    end
  end

  // grid point setup: base and numerator of the step division
  bbvg_pkg::frame_t fr0;
  logic [LW-1:0]    hu0, iu0, hv0, iv0, ru0, rv0;
  logic             lo_u0, lo_v0;
  logic [IW-1:0]    ku0, kv0;
  grid_t            grid0;

  always_comb begin
    fr0   = bbvg_pkg::frame_of(in_face);
    hu0   = pick(fr0.u_ax, half_x, half_y, half_z);
    iu0   = pick(fr0.u_ax, inner_x, inner_y, inner_z);
    hv0   = pick(fr0.v_ax, half_x, half_y, half_z);
    iv0   = pick(fr0.v_ax, inner_x, inner_y, inner_z);
    ru0   = hu0 - iu0;
    rv0   = hv0 - iv0;
    lo_u0 = 32'(in_u) <= 32'(seg_sat);
    lo_v0 = 32'(in_v) <= 32'(seg_sat);
    ku0   = lo_u0 ? in_u : IW'(32'(in_u) - 32'(seg_sat) - 32'd1);
    kv0   = lo_v0 ? in_v : IW'(32'(in_v) - 32'(seg_sat) - 32'd1);
    grid0.valid  = in_vld;
    grid0.bad    = (in_face > bbvg_pkg::FACE_LEFT) || (32'(in_u) >= 32'(grid_cnt)) ||
                   (32'(in_v) >= 32'(grid_cnt));
    grid0.face   = in_face;
    grid0.on     = bevel_on;
    grid0.u_zero = in_u == '0;
    grid0.v_zero = in_v == '0;
    grid0.base_u = lo_u0 ? -$signed(PSW'(hu0)) : $signed(PSW'(iu0));
    grid0.base_v = lo_v0 ? -$signed(PSW'(hv0)) : $signed(PSW'(iv0));
  end

  // stage 1: step numerators
  grid_t             grid1;
  logic [GNUM_W-1:0] num_u1, num_v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid1.valid <= 1'b0;
    end else if (en) begin
      grid1 <= grid0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_u1 <= GNUM_W'(ku0) * GNUM_W'(ru0);
      num_v1 <= GNUM_W'(kv0) * GNUM_W'(rv0);
    end
  end

  logic [LW-1:0] step_u, step_v;

  bbvg_div #(.NUM_W(GNUM_W), .DEN_W(SEG_W), .QUO_W(LW)) u_div_gu (
    .clk(clk), .en(en), .num(num_u1), .den(seg_sat), .quo(step_u)
  );

  bbvg_div #(.NUM_W(GNUM_W), .DEN_W(SEG_W), .QUO_W(LW)) u_div_gv (
    .clk(clk), .en(en), .num(num_v1), .den(seg_sat), .quo(step_v)
  );

  grid_t gd [LW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LW; i++) gd[i].valid <= 1'b0;
    end else if (en) begin
      gd[0] <= grid1;
      for (int i = 1; i < LW; i++) gd[i] <= gd[i-1];
    end
  end

  // grid coordinates
  grid_t            gq;
  bbvg_pkg::frame_t fr1;
  logic [LW-1:0]    hu1, hv1;
  loc_t             loc0;

  always_comb begin
    gq  = gd[LW-1];
    fr1 = bbvg_pkg::frame_of(gq.face);
    hu1 = pick(fr1.u_ax, half_x, half_y, half_z);
    hv1 = pick(fr1.v_ax, half_x, half_y, half_z);
    loc0.valid = gq.valid;
    loc0.bad   = gq.bad;
    loc0.face  = gq.face;
    loc0.on    = gq.on;
    if (gq.on) begin
      loc0.lu = gq.base_u + $signed(PSW'(step_u));
      loc0.lv = gq.base_v + $signed(PSW'(step_v));
    end else begin
      loc0.lu = gq.u_zero ? -$signed(PSW'(hu1)) : $signed(PSW'(hu1));
      loc0.lv = gq.v_zero ? -$signed(PSW'(hv1)) : $signed(PSW'(hv1));
    end
  end

  loc_t loc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loc1.valid <= 1'b0;
    end else if (en) begin
      loc1 <= loc0;
    end
  end

  // clamp to the inner square and bevel direction
  bbvg_pkg::frame_t      fr2;
  logic [LW-1:0]         iu2, iv2, hn2, in2;
  logic signed [PSW-1:0] isu, isv, cu2, cv2, du2, dv2, alu, alv;
  logic                  flat_u, flat_v;
  geo_t                  geo0;

  always_comb begin
    fr2 = bbvg_pkg::frame_of(loc1.face);
    iu2 = pick(fr2.u_ax, inner_x, inner_y, inner_z);
    iv2 = pick(fr2.v_ax, inner_x, inner_y, inner_z);
    hn2 = pick(fr2.n_ax, half_x, half_y, half_z);
    in2 = pick(fr2.n_ax, inner_x, inner_y, inner_z);
    isu = $signed(PSW'(iu2));
    isv = $signed(PSW'(iv2));
    alu = loc1.lu[PSW-1] ? -loc1.lu : loc1.lu;
    alv = loc1.lv[PSW-1] ? -loc1.lv : loc1.lv;
    flat_u = alu <= isu;
    flat_v = alv <= isv;
    cu2 = (loc1.lu < -isu) ? -isu : ((loc1.lu > isu) ? isu : loc1.lu);
    cv2 = (loc1.lv < -isv) ? -isv : ((loc1.lv > isv) ? isv : loc1.lv);
    du2 = loc1.lu - cu2;
    dv2 = loc1.lv - cv2;
    geo0.valid = loc1.valid;
    geo0.bad   = loc1.bad;
    geo0.face  = loc1.face;
    geo0.bevel = loc1.on & ~(flat_u & flat_v);
    geo0.lu    = loc1.lu;
    geo0.lv    = loc1.lv;
    geo0.cu    = cu2;
    geo0.cv    = cv2;
    geo0.neg_u = du2[PSW-1];
    geo0.neg_v = dv2[PSW-1];
    geo0.mag_n = hn2 - in2;
    geo0.mag_u = LW'(du2[PSW-1] ? -du2 : du2);
    geo0.mag_v = LW'(dv2[PSW-1] ? -dv2 : dv2);
  end

  geo_t geo1, geo_sq, geo_sum;
  logic [2*LW-1:0] sq_n, sq_u, sq_v;
  logic [SQ_W-1:0] len_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      geo1.valid    <= 1'b0;
      geo_sq.valid  <= 1'b0;
      geo_sum.valid <= 1'b0;
    end else if (en) begin
      geo1    <= geo0;
      geo_sq  <= geo1;
      geo_sum <= geo_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n   <= (2*LW)'(geo1.mag_n) * (2*LW)'(geo1.mag_n);
      sq_u   <= (2*LW)'(geo1.mag_u) * (2*LW)'(geo1.mag_u);
      sq_v   <= (2*LW)'(geo1.mag_v) * (2*LW)'(geo1.mag_v);
      len_sq <= SQ_W'(sq_n) + SQ_W'(sq_u) + SQ_W'(sq_v);
    end
  end

  logic [LEN2_W-1:0] len;

  bbvg_sqrt #(.IN_W(SQ_W)) u_sqrt (
    .clk(clk), .en(en), .rad(len_sq), .root(len)
  );

  geo_t gs [LEN2_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEN2_W; i++) gs[i].valid <= 1'b0;
    end else if (en) begin
      gs[0] <= geo_sum;
      for (int i = 1; i < LEN2_W; i++) gs[i] <= gs[i-1];
    end
  end

  // scale by radius and by one in Q2.14, then add half the length for rounding
  geo_t              geo_m, geo_a;
  logic [2*LW-1:0]   pr_n, pr_u, pr_v, pq_n, pq_u, pq_v;
  logic [LEN2_W-1:0] len_m, len_a;
  logic [DN_W-1:0]   nr_n, nr_u, nr_v, nq_n, nq_u, nq_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      geo_m.valid <= 1'b0;
      geo_a.valid <= 1'b0;
    end else if (en) begin
      geo_m <= gs[LEN2_W-1];
      geo_a <= geo_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_n  <= (2*LW)'(gs[LEN2_W-1].mag_n) * (2*LW)'(bevel_radius);
      pr_u  <= (2*LW)'(gs[LEN2_W-1].mag_u) * (2*LW)'(bevel_radius);
      pr_v  <= (2*LW)'(gs[LEN2_W-1].mag_v) * (2*LW)'(bevel_radius);
      pq_n  <= (2*LW)'(gs[LEN2_W-1].mag_n) << bbvg_pkg::Q_SHIFT;
      pq_u  <= (2*LW)'(gs[LEN2_W-1].mag_u) << bbvg_pkg::Q_SHIFT;
      pq_v  <= (2*LW)'(gs[LEN2_W-1].mag_v) << bbvg_pkg::Q_SHIFT;
      len_m <= len;
      nr_n  <= DN_W'(pr_n) + DN_W'(len_m >> 1);
      nr_u  <= DN_W'(pr_u) + DN_W'(len_m >> 1);
      nr_v  <= DN_W'(pr_v) + DN_W'(len_m >> 1);
      nq_n  <= DN_W'(pq_n) + DN_W'(len_m >> 1);
      nq_u  <= DN_W'(pq_u) + DN_W'(len_m >> 1);
      nq_v  <= DN_W'(pq_v) + DN_W'(len_m >> 1);
      len_a <= len_m;
    end
  end

  logic [QUO2_W-1:0] qr_n, qr_u, qr_v, qq_n, qq_u, qq_v;

  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_rn (
    .clk(clk), .en(en), .num(nr_n), .den(len_a), .quo(qr_n)
  );
  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_ru (
    .clk(clk), .en(en), .num(nr_u), .den(len_a), .quo(qr_u)
  );
  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_rv (
    .clk(clk), .en(en), .num(nr_v), .den(len_a), .quo(qr_v)
  );
  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_qn (
    .clk(clk), .en(en), .num(nq_n), .den(len_a), .quo(qq_n)
  );
  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_qu (
    .clk(clk), .en(en), .num(nq_u), .den(len_a), .quo(qq_u)
  );
  bbvg_div #(.NUM_W(DN_W), .DEN_W(LEN2_W), .QUO_W(QUO2_W)) u_div_qv (
    .clk(clk), .en(en), .num(nq_v), .den(len_a), .quo(qq_v)
  );

  geo_t gn [QUO2_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUO2_W; i++) gn[i].valid <= 1'b0;
    end else if (en) begin
      gn[0] <= geo_a;
      for (int i = 1; i < QUO2_W; i++) gn[i] <= gn[i-1];
    end
  end

  // vertex in the face frame
  geo_t                  gf;
  bbvg_pkg::frame_t      fr3;
  logic [LW-1:0]         hn3, in3;
  logic signed [FRW-1:0] sru, srv, squ_f, sqv_f;
  fin_t                  fin0;

  always_comb begin
    gf    = gn[QUO2_W-1];
    fr3   = bbvg_pkg::frame_of(gf.face);
    hn3   = pick(fr3.n_ax, half_x, half_y, half_z);
    in3   = pick(fr3.n_ax, inner_x, inner_y, inner_z);
    sru   = $signed(FRW'(qr_u));
    srv   = $signed(FRW'(qr_v));
    squ_f = $signed(FRW'(qq_u));
    sqv_f = $signed(FRW'(qq_v));
    fin0.valid = gf.valid;
    fin0.bad   = gf.bad;
    fin0.face  = gf.face;
    fin0.lu    = gf.lu;
    fin0.lv    = gf.lv;
    if (gf.bevel) begin
      fin0.pn = $signed(FRW'(in3)) + $signed(FRW'(qr_n));
      fin0.pu = FRW'(gf.cu) + (gf.neg_u ? -sru : sru);
      fin0.pv = FRW'(gf.cv) + (gf.neg_v ? -srv : srv);
      fin0.nn = $signed(NW'(qq_n));
      fin0.nu = NW'(gf.neg_u ? -squ_f : squ_f);
      fin0.nv = NW'(gf.neg_v ? -sqv_f : sqv_f);
    end else begin
      fin0.pn = $signed(FRW'(hn3));
      fin0.pu = FRW'(gf.lu);
      fin0.pv = FRW'(gf.lv);
      fin0.nn = bbvg_pkg::Q_ONE;
      fin0.nu = '0;
      fin0.nv = '0;
    end
  end

  fin_t fin1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fin1.valid <= 1'b0;
    end else if (en) begin
      fin1 <= fin0;
    end
  end

  // map the face frame onto x/y/z, lift z and saturate
  bbvg_pkg::frame_t     fr4;
  logic [LW-1:0]        hu4, hv4;
  logic signed [PW-1:0] pax [3];
  logic signed [NW-1:0] nax [3];
  logic signed [PW-1:0] pn4, pu4, pv4;
  logic signed [NW-1:0] nn4, nu4, nv4;

  always_comb begin
    fr4 = bbvg_pkg::frame_of(fin1.face);
    hu4 = pick(fr4.u_ax, half_x, half_y, half_z);
    hv4 = pick(fr4.v_ax, half_x, half_y, half_z);
    pn4 = fr4.n_neg ? -PW'(fin1.pn) : PW'(fin1.pn);
    pu4 = fr4.u_neg ? -PW'(fin1.pu) : PW'(fin1.pu);
    pv4 = fr4.v_neg ? -PW'(fin1.pv) : PW'(fin1.pv);
    nn4 = fr4.n_neg ? -fin1.nn : fin1.nn;
    nu4 = fr4.u_neg ? -fin1.nu : fin1.nu;
    nv4 = fr4.v_neg ? -fin1.nv : fin1.nv;
    for (int a = 0; a < 3; a++) begin
      if (fr4.n_ax == 2'(a)) begin
        pax[a] = pn4;
        nax[a] = nn4;
      end else if (fr4.u_ax == 2'(a)) begin
        pax[a] = pu4;
        nax[a] = nu4;
      end else begin
        pax[a] = pv4;
        nax[a] = nv4;
      end
    end
    pax[bbvg_pkg::AX_Z] = pax[bbvg_pkg::AX_Z] + $signed(PW'(half_z));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else if (en) begin
      vertex_valid <= fin1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin1.bad) begin
        pos_x    <= '0;
        pos_y    <= '0;
        pos_z    <= '0;
        norm_x   <= '0;
        norm_y   <= '0;
        norm_z   <= '0;
        surf_u   <= '0;
        surf_v   <= '0;
        index_ok <= 1'b0;
      end else begin
        pos_x    <= sat_pos(pax[bbvg_pkg::AX_X]);
        pos_y    <= sat_pos(pax[bbvg_pkg::AX_Y]);
        pos_z    <= sat_pos(pax[bbvg_pkg::AX_Z]);
        norm_x   <= nax[bbvg_pkg::AX_X];
        norm_y   <= nax[bbvg_pkg::AX_Y];
        norm_z   <= nax[bbvg_pkg::AX_Z];
        surf_u   <= bbvg_pkg::SURF_W'(fin1.lu + $signed(PSW'(hu4)));
        surf_v   <= bbvg_pkg::SURF_W'(fin1.lv + $signed(PSW'(hv4)));
        index_ok <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/bbvg_div.sv @@
// pipelined restoring divider, one quotient bit per stage, quotient must fit QUO_W bits
module bbvg_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 8,
  parameter int QUO_W = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = NUM_W + DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [CW-1:0]    dsh;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    assign dsh = CW'(den_in) << (QUO_W - 1 - j);
    assign ge  = CW'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? NUM_W'(CW'(rem_in) - dsh) : rem_in;
        den_r[j] <= den_in;
        quo_r[j] <= ge ? (quo_in | (QUO_W'(1) << (QUO_W - 1 - j))) : quo_in;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

@@ hw/rtl/bbvg_sqrt.sv @@
// pipelined integer square root (floor), one result bit per stage
module bbvg_sqrt #(
  parameter int IN_W = 50
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int W     = IN_W + 1;

  logic [W-1:0] x_r [OUT_W];
  logic [W-1:0] r_r [OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (IN_W - 2 - 2 * j);
    logic [W-1:0] x_in;
    logic [W-1:0] r_in;
    logic [W-1:0] t;
    logic         ge;

    if (j == 0) begin : g_first
      assign x_in = W'(rad);
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_r[j-1];
      assign r_in = r_r[j-1];
    end

    assign t  = r_in + BIT;
    assign ge = x_in >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j] <= ge ? x_in - t : x_in;
        r_r[j] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
      end
    end
  end

  assign root = OUT_W'(r_r[OUT_W-1]);

endmodule

@@ tb/bevel_box_vertex_checker.sv @@
// checker for the bevel box vertex generator: predicts each vertex and compares it
module bevel_box_vertex_checker
  import bbvg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [FACE_W-1:0]        face,
  input  logic [IDX_W-1:0]         u_index,
  input  logic [IDX_W-1:0]         v_index,
  input  logic                     vertex_valid,
  input  logic                     vertex_stall,
  input  logic [POS_W-1:0]         pos_x,
  input  logic [POS_W-1:0]         pos_y,
  input  logic [POS_W-1:0]         pos_z,
  input  logic [NRM_W-1:0]         norm_x,
  input  logic [NRM_W-1:0]         norm_y,
  input  logic [NRM_W-1:0]         norm_z,
  input  logic [SURF_W-1:0]        surf_u,
  input  logic [SURF_W-1:0]        surf_v,
  input  logic                     index_ok,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LEN_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [POS_W-1:0]  pos[3];
    logic [NRM_W-1:0]  nrm[3];
    logic [SURF_W-1:0] su;
    logic [SURF_W-1:0] sv;
    logic              ok;
  } vertex_t;

  vertex_t vertex_expected[$];
  longint half_len[3];
  longint inner_len[3];
  longint radius;
  longint segments;

  initial fail_count = 0;
  assign pending = vertex_expected.size();

  function automatic longint root_floor(input longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // rounded magnitude scaling, sign follows d
  function automatic longint scale_dir(input longint d, input longint mul, input longint len);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = (mag * mul + len / 2) / len;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint grid_coord(input bit on, input longint s, input longint i,
                                        input longint h, input longint in_len);
    if (!on) return (i == 0) ? -h : h;
    if (i <= s) return -h + (i * (h - in_len)) / s;
    return in_len + ((i - s - 1) * (h - in_len)) / s;
  endfunction

  function automatic vertex_t predict_vertex(input logic [FACE_W-1:0] f,
                                             input logic [IDX_W-1:0] ui,
                                             input logic [IDX_W-1:0] vi);
    vertex_t vt;
    longint pos[3], nrm[3];
    longint s, cnt, lu, lv, iu, iv, cu, cv, dn, du, dv, len, p;
    int na, ua, va, ns, us, vs;
    bit on, flat;
    pos = '{0, 0, 0};
    nrm = '{0, 0, 0};
    vt.pos = '{0, 0, 0};
    vt.nrm = '{0, 0, 0};
    vt.su = '0;
    vt.sv = '0;
    vt.ok = 1'b0;
    s = (segments > MAX_SEGMENTS) ? MAX_SEGMENTS : segments;
    on = s > 0 && radius > 0 && half_len[0] > inner_len[0] && half_len[1] > inner_len[1]
         && half_len[2] > inner_len[2];
    cnt = on ? 2 * (s + 1) : 2;
    if (f > FACE_LEFT || ui >= cnt || vi >= cnt) return vt;
    case (f)
      FACE_FRONT:  begin na = 1; ns =  1; ua = 1 - 1; us =  1; va = 2; vs = -1; end
      FACE_BACK:   begin na = 1; ns = -1; ua = 0; us = -1; va = 2; vs = -1; end
      FACE_TOP:    begin na = 2; ns =  1; ua = 0; us =  1; va = 1; vs =  1; end
      FACE_BOTTOM: begin na = 2; ns = -1; ua = 0; us =  1; va = 1; vs = -1; end
      FACE_RIGHT:  begin na = 0; ns =  1; ua = 1; us = -1; va = 2; vs = -1; end
      default:     begin na = 0; ns = -1; ua = 1; us =  1; va = 2; vs = -1; end
    endcase
    lu = grid_coord(on, s, ui, half_len[ua], inner_len[ua]);
    lv = grid_coord(on, s, vi, half_len[va], inner_len[va]);
    iu = inner_len[ua];
    iv = inner_len[va];
    flat = ((lu < 0) ? -lu : lu) <= iu && ((lv < 0) ? -lv : lv) <= iv;
    if (!on || flat) begin
      pos[na] = ns * half_len[na];
      pos[ua] = us * lu;
      pos[va] = vs * lv;
      nrm[na] = ns * 16384;
    end else begin
      cu = (lu < -iu) ? -iu : ((lu > iu) ? iu : lu);
      cv = (lv < -iv) ? -iv : ((lv > iv) ? iv : lv);
      dn = half_len[na] - inner_len[na];
      du = lu - cu;
      dv = lv - cv;
      len = root_floor(dn * dn + du * du + dv * dv);
      pos[na] = ns * (inner_len[na] + scale_dir(dn, radius, len));
      pos[ua] = us * (cu + scale_dir(du, radius, len));
      pos[va] = vs * (cv + scale_dir(dv, radius, len));
      nrm[na] = ns * scale_dir(dn, 16384, len);
      nrm[ua] = us * scale_dir(du, 16384, len);
      nrm[va] = vs * scale_dir(dv, 16384, len);
    end
    pos[2] = pos[2] + half_len[2];
    for (int k = 0; k < 3; k++) begin
      p = pos[k];
      if (p > 33554431) p = 33554431;
      if (p < -33554432) p = -33554432;
      vt.pos[k] = p[POS_W-1:0];
      vt.nrm[k] = nrm[k][NRM_W-1:0];
    end
    p = lu + half_len[ua];
    vt.su = p[SURF_W-1:0];
    p = lv + half_len[va];
    vt.sv = p[SURF_W-1:0];
    vt.ok = 1'b1;
    return vt;
  endfunction

  function automatic void check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    vertex_t vt;
    if (rst) begin
      half_len = '{HALF_RST, HALF_RST, HALF_RST};
      inner_len = '{INNER_RST, INNER_RST, INNER_RST};
      radius = RADIUS_RST;
      segments = SEG_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_X:   half_len[0] = cfg_data;
          REG_HALF_Y:   half_len[1] = cfg_data;
          REG_HALF_Z:   half_len[2] = cfg_data;
          REG_INNER_X:  inner_len[0] = cfg_data;
          REG_INNER_Y:  inner_len[1] = cfg_data;
          REG_INNER_Z:  inner_len[2] = cfg_data;
          REG_RADIUS:   radius = cfg_data;
          REG_SEGMENTS: segments = cfg_data[SEG_CFG_W-1:0];
          default: ;
        endcase
      end
      if (vertex_valid && !vertex_stall) begin
        if (vertex_expected.size() == 0) begin
          $error("vertex with no item waiting");
          fail_count++;
        end else begin
          vt = vertex_expected.pop_front();
          check_field("pos_x", vt.pos[0], pos_x);
          check_field("pos_y", vt.pos[1], pos_y);
          check_field("pos_z", vt.pos[2], pos_z);
          check_field("norm_x", vt.nrm[0], norm_x);
          check_field("norm_y", vt.nrm[1], norm_y);
          check_field("norm_z", vt.nrm[2], norm_z);
          check_field("surf_u", vt.su, surf_u);
          check_field("surf_v", vt.sv, surf_v);
          check_field("index_ok", vt.ok, index_ok);
        end
      end
      if (item_valid && !item_stall)
        vertex_expected.push_back(predict_vertex(face, u_index, v_index));
    end
  end

endmodule

@@ tb/bevel_box_vertex_generator_top_test.sv @@
// stimulus and verdict for the bevel box vertex generator
module bevel_box_vertex_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bbvg_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [FACE_W-1:0]     face = '0;
  logic [IDX_W-1:0]      u_index = '0;
  logic [IDX_W-1:0]      v_index = '0;
  logic                  vertex_valid;
  logic                  vertex_stall = 1'b0;
  logic [POS_W-1:0]      pos_x, pos_y, pos_z;
  logic [NRM_W-1:0]      norm_x, norm_y, norm_z;
  logic [SURF_W-1:0]     surf_u, surf_v;
  logic                  index_ok;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LEN_W-1:0]      cfg_data = '0;
  int                    fail_count;
  int                    pending;

  bit     quiet = 0;
  bit     hold_req = 0;
  int     quiet_cycles = 0;
  int     grid_count = 10;
  longint setting[8];

  always #6 clk = ~clk;

  bevel_box_vertex_generator_top DUT (.*);
  bevel_box_vertex_checker checker_i (.*);

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        vertex_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      vertex_stall <= !quiet && $urandom_range(99) < 7;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (vertex_valid && !vertex_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put_item(input logic [FACE_W-1:0] f, input int u, input int v);
    while (!quiet && $urandom_range(99) < 7) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    face <= f;
    u_index <= u[IDX_W-1:0];
    v_index <= v[IDX_W-1:0];
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input longint vals[8]);
    longint s;
    bit on;
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data <= vals[i][LEN_W-1:0];
      setting[i] = (i == REG_SEGMENTS) ? (vals[i] & 127) : (vals[i] & 24'hFFFFFF);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    s = (setting[REG_SEGMENTS] > MAX_SEGMENTS) ? MAX_SEGMENTS : setting[REG_SEGMENTS];
    on = s > 0 && setting[REG_RADIUS] > 0 && setting[REG_HALF_X] > setting[REG_INNER_X]
         && setting[REG_HALF_Y] > setting[REG_INNER_Y]
         && setting[REG_HALF_Z] > setting[REG_INNER_Z];
    grid_count = on ? 2 * (s + 1) : 2;
  endtask

  // mostly in-grid points, some out-of-range noise
  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85)
        put_item(FACE_W'($urandom_range(5)), $urandom_range(grid_count - 1),
                 $urandom_range(grid_count - 1));
      else
        put_item(FACE_W'($urandom_range(7)), $urandom_range(255), $urandom_range(255));
    end
  endtask

  initial begin
    longint phases[8][8];
    phases[0] = '{256, 256, 256, 192, 192, 192, 64, 4};
    phases[1] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF};
    phases[2] = '{1000, 700, 300, 0, 500, 100, 5000, 7};
    phases[3] = '{5, 9, 3, 2, 4, 1, 3, 3};
    phases[4] = '{4000, 3000, 2000, 100, 100, 100, 50, 0};
    phases[5] = '{4000, 3000, 2000, 100, 100, 100, 0, 9};
    phases[6] = '{800, 800, 800, 800, 200, 200, 40, 5};
    phases[7] = '{12345, 23456, 34567, 12000, 20000, 30000, 777, 64};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < 8; p++) begin
      configure(phases[p]);
      if (p == 0) begin
        // two corners on every face, then a middle point and out-of-range cases
        for (int f = 0; f < 6; f++) begin
          put_item(f[FACE_W-1:0], 0, 0);
          put_item(f[FACE_W-1:0], grid_count - 1, grid_count - 1);
        end
        put_item(FACE_TOP, grid_count / 2, grid_count / 2 - 1);
        put_item(3'd6, 0, 0);
        put_item(3'd7, 1, 1);
        put_item(FACE_FRONT, grid_count, 0);
        put_item(FACE_BACK, 0, 255);
        put_item(FACE_LEFT, 255, 3);
      end
      quiet = (p == 3);
      if (p == 2) begin
        random_items(20);
        hold_req = 1;
        random_items(62);
      end else if (p == 1) begin
        random_items(40);
        drain();
        random_items(42);
      end else begin
        random_items(82);
      end
      quiet = 0;
    end
    drain();
    repeat (120) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ bevel_box_vertex_generator_top.f @@
hw/rtl/bbvg_pkg.sv
hw/rtl/bbvg_div.sv
hw/rtl/bbvg_sqrt.sv
hw/rtl/bevel_box_vertex_generator_top.sv
tb/bevel_box_vertex_checker.sv
tb/bevel_box_vertex_generator_top_test.sv
